[rtl/upi_pkg.sv]
// shared types, constants and the arctangent table of the pose integrator
package upi_pkg;

  localparam int TS_W       = 16;
  localparam int SPEED_W    = 24;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ATAN_W     = 30;
  localparam int ATAN_IDX_W = 5;

  localparam logic KIND_ADVANCE = 1'b0;
  localparam logic KIND_LOAD    = 1'b1;

  // reciprocal of the cordic gain, scaled by 2^31
  localparam logic signed [31:0] INV_GAIN = 32'sd1304065748;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINEAR_SPEED  = 3'd0,
    CFG_ANGULAR_SPEED = 3'd1,
    CFG_START_X       = 3'd2,
    CFG_START_Y       = 3'd3,
    CFG_START_HEADING = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic capture;
    logic mul_d;
    logic mul_h;
    logic mul_k;
    logic prep;
    logic iter;
    logic fin;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic iter_last;
  } sts_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      5'd24:   r = 30'd41;
      5'd25:   r = 30'd20;
      5'd26:   r = 30'd10;
      5'd27:   r = 30'd5;
      5'd28:   r = 30'd3;
      5'd29:   r = 30'd1;
      5'd30:   r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/upi_if.sv]
// channel interfaces: tick input, pose output, configuration writes
interface upi_tick_if;
  import upi_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TS_W-1:0]   time_step;
  modport source(output valid, kind, time_step, input ready);
  modport sink(input valid, kind, time_step, output ready);
endinterface

interface upi_pose_if;
  import upi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pose_x;
  logic signed [POS_W-1:0]  pose_y;
  logic signed [HEAD_W-1:0] pose_heading;
  logic                     saturated;
  modport source(output valid, pose_x, pose_y, pose_heading, saturated, input ready);
  modport sink(input valid, pose_x, pose_y, pose_heading, saturated, output ready);
endinterface

interface upi_cfg_if;
  import upi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/upi_regs.sv]
// configuration register file
module upi_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  upi_cfg_if.sink                              cfg,
  output logic signed [upi_pkg::SPEED_W-1:0]   linear_speed,
  output logic signed [upi_pkg::SPEED_W-1:0]   angular_speed,
  output logic signed [upi_pkg::POS_W-1:0]     start_x,
  output logic signed [upi_pkg::POS_W-1:0]     start_y,
  output logic signed [upi_pkg::HEAD_W-1:0]    start_heading
);
  import upi_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_speed  <= '0;
      angular_speed <= '0;
      start_x       <= '0;
      start_y       <= '0;
      start_heading <= '0;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_LINEAR_SPEED:  linear_speed  <= cfg.data[SPEED_W-1:0];
        CFG_ANGULAR_SPEED: angular_speed <= cfg.data[SPEED_W-1:0];
        CFG_START_X:       start_x       <= cfg.data[POS_W-1:0];
        CFG_START_Y:       start_y       <= cfg.data[POS_W-1:0];
        CFG_START_HEADING: start_heading <= cfg.data[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/upi_ctrl.sv]
// sequencing state machine: multiplies, cordic iterations and result handoff
module upi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  upi_pkg::sts_t sts,
  output upi_pkg::cmd_t cmd
);
  import upi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_MUL_H,
    ST_MUL_K,
    ST_PREP,
    ST_ITER,
    ST_FIN,
    ST_HOLD
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (in_kind == KIND_LOAD) ? ST_HOLD : ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        cmd.mul_d  = 1'b1;
        state_next = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd.mul_h  = 1'b1;
        state_next = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd.mul_k  = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/upi_dpath.sv]
// datapath: shared multiplier, iterative cordic rotator and pose state
module upi_dpath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  upi_pkg::cmd_t                       cmd,
  output upi_pkg::sts_t                       sts,
  input  logic                                kind,
  input  logic [upi_pkg::TS_W-1:0]            time_step,
  input  logic signed [upi_pkg::SPEED_W-1:0]  linear_speed,
  input  logic signed [upi_pkg::SPEED_W-1:0]  angular_speed,
  input  logic signed [upi_pkg::POS_W-1:0]    start_x,
  input  logic signed [upi_pkg::POS_W-1:0]    start_y,
  input  logic signed [upi_pkg::HEAD_W-1:0]   start_heading,
  output logic signed [upi_pkg::POS_W-1:0]    pose_x,
  output logic signed [upi_pkg::POS_W-1:0]    pose_y,
  output logic signed [upi_pkg::HEAD_W-1:0]   pose_heading,
  output logic                                saturated
);
  import upi_pkg::*;

  localparam int CNT_W  = $clog2(CORDIC_STEPS);
  localparam int MA_W   = SPEED_W + 1;
  localparam int MB_W   = 32;
  localparam int PROD_W = MA_W + MB_W;
  localparam int VEC_W  = 34;
  localparam int DX_W   = VEC_W - 8;
  localparam int SUM_W  = POS_W + 2;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CORDIC_STEPS - 1);

  logic                       kind_r;
  logic [TS_W-1:0]            ts_r;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [SPEED_W-1:0]  d_r;
  logic signed [SPEED_W-1:0]  dh_r;
  logic signed [VEC_W-1:0]    vx;
  logic signed [VEC_W-1:0]    vy;
  logic signed [31:0]         z;
  logic [CNT_W-1:0]           cnt;
  logic signed [VEC_W-1:0]    vx0;
  logic                       fold;
  logic signed [HEAD_W-1:0]   h_adj;
  logic signed [VEC_W-1:0]    sx;
  logic signed [VEC_W-1:0]    sy;
  logic signed [31:0]         at;
  logic signed [VEC_W-1:0]    vx_rnd;
  logic signed [VEC_W-1:0]    vy_rnd;
  logic signed [DX_W-1:0]     dx_r;
  logic signed [DX_W-1:0]     dy_r;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic                       sat_x;
  logic                       sat_y;
  logic signed [POS_W-1:0]    clamp_x;
  logic signed [POS_W-1:0]    clamp_y;

  // shared multiplier operand select
  always_comb begin
    mul_a = MA_W'(linear_speed);
    mul_b = $signed({{(MB_W-TS_W){1'b0}}, ts_r});
    if (cmd.mul_h) begin
      mul_a = MA_W'(angular_speed);
    end else if (cmd.mul_k) begin
      mul_a = MA_W'(d_r);
      mul_b = INV_GAIN;
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_rnd = prod + PROD_W'(32768);

  // prescaled vector and quarter-turn fold
  assign vx0   = prod[PROD_W-1:23];
  assign fold  = (pose_heading > 16'sd16384) || (pose_heading < -16'sd16384);
  assign h_adj = fold ? (pose_heading ^ 16'sh8000) : pose_heading;

  assign sx = vx >>> cnt;
  assign sy = vy >>> cnt;
  assign at = $signed({2'b00, atan_lut(ATAN_IDX_W'(cnt))});

  assign vx_rnd = vx + VEC_W'(128);
  assign vy_rnd = vy + VEC_W'(128);

  assign sts.iter_last = (cnt == LAST_CNT);

  // position update with saturation
  assign sum_x = SUM_W'(pose_x) + SUM_W'(dx_r);
  assign sum_y = SUM_W'(pose_y) + SUM_W'(dy_r);
  assign sat_x = (sum_x[SUM_W-1:POS_W-1] != '0) && (sum_x[SUM_W-1:POS_W-1] != '1);
  assign sat_y = (sum_y[SUM_W-1:POS_W-1] != '0) && (sum_y[SUM_W-1:POS_W-1] != '1);
  assign clamp_x = !sat_x ? sum_x[POS_W-1:0] :
                   sum_x[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  assign clamp_y = !sat_y ? sum_y[POS_W-1:0] :
                   sum_y[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      ts_r   <= time_step;
    end
    if (cmd.mul_d || cmd.mul_h || cmd.mul_k) begin
      prod <= mul_p;
    end
    if (cmd.mul_h) begin
      d_r <= prod_rnd[SPEED_W+15:16];
    end
    if (cmd.mul_k) begin
      dh_r <= prod_rnd[SPEED_W+15:16];
    end
    if (cmd.prep) begin
      vx  <= fold ? -vx0 : vx0;
      vy  <= '0;
      z   <= {h_adj, 16'h0000};
      cnt <= '0;
    end else if (cmd.iter) begin
      if (!z[31]) begin
        vx <= vx - sy;
        vy <= vy + sx;
        z  <= z - at;
      end else begin
        vx <= vx + sy;
        vy <= vy - sx;
        z  <= z + at;
      end
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.fin) begin
      dx_r <= vx_rnd[VEC_W-1:8];
      dy_r <= vy_rnd[VEC_W-1:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      saturated    <= 1'b0;
    end else if (cmd.commit) begin
      if (kind_r == KIND_LOAD) begin
        pose_x       <= start_x;
        pose_y       <= start_y;
        pose_heading <= start_heading;
        saturated    <= 1'b0;
      end else begin
        pose_x       <= clamp_x;
        pose_y       <= clamp_y;
        pose_heading <= pose_heading + dh_r[HEAD_W-1:0];
        saturated    <= sat_x || sat_y;
      end
    end
  end

endmodule

[rtl/unicycle_pose_integrator_top.sv]
// advance item: multiplies, prep, cordic iterations and fin run in order, then the hold state
// commits the result once the output beat is free; load item: straight to the hold state
// one item in flight; the next beat is taken once the state machine is back in idle,
// which it reaches as the result is registered; the cordic runs one step per cycle
// reset clears pose, heading, configuration registers and the output beat
module unicycle_pose_integrator_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  upi_tick_if.sink  tick,
  upi_pose_if.source pose,
  upi_cfg_if.sink   cfg
);
  import upi_pkg::*;

  cmd_t                      cmd;
  sts_t                      sts;
  logic signed [SPEED_W-1:0] linear_speed;
  logic signed [SPEED_W-1:0] angular_speed;
  logic signed [POS_W-1:0]   start_x;
  logic signed [POS_W-1:0]   start_y;
  logic signed [HEAD_W-1:0]  start_heading;

  upi_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .linear_speed  (linear_speed),
    .angular_speed (angular_speed),
    .start_x       (start_x),
    .start_y       (start_y),
    .start_heading (start_heading)
  );

  upi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_kind   (tick.kind),
    .in_ready  (tick.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  upi_dpath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (tick.kind),
    .time_step     (tick.time_step),
    .linear_speed  (linear_speed),
    .angular_speed (angular_speed),
    .start_x       (start_x),
    .start_y       (start_y),
    .start_heading (start_heading),
    .pose_x        (pose.pose_x),
    .pose_y        (pose.pose_y),
    .pose_heading  (pose.pose_heading),
    .saturated     (pose.saturated)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> !tick.ready)
    else $error("input beat taken while an item is in flight");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> pose.valid)
    else $error("result commit did not raise output valid");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !pose.valid || pose.ready)
    else $error("result overwritten before output beat was taken");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command active");

endmodule

[test/upi_pose_checker.sv]
// pose checker: mirrors register writes, predicts every pose beat and compares it field by field
module upi_pose_checker #(
  parameter int STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  upi_tick_if  tick,
  upi_pose_if  pose,
  upi_cfg_if   cfg,
  output int   errors,
  output int   poses_seen,
  output int   sat_seen
);
  import upi_pkg::*;

  localparam int     ROUNDS  = (STEPS > 31) ? 31 : STEPS;
  localparam longint INV_K   = 64'sd1304065748;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint QUARTER = 64'sd16384;
  localparam longint HALF    = 64'sd32768;

  // arctangent of 2^-i, 2^32 units per turn
  localparam longint ATAN_TURN [0:30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [HEAD_W-1:0] heading;
    logic                     saturated;
  } pose_t;

  logic signed [SPEED_W-1:0] lin_speed;
  logic signed [SPEED_W-1:0] ang_speed;
  logic signed [POS_W-1:0]   start_x;
  logic signed [POS_W-1:0]   start_y;
  logic signed [HEAD_W-1:0]  start_heading;
  longint                    cur_x;
  longint                    cur_y;
  logic signed [HEAD_W-1:0]  cur_heading;
  pose_t                     pending_poses[$];

  function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_LINEAR_SPEED:  lin_speed = data[SPEED_W-1:0];
      CFG_ANGULAR_SPEED: ang_speed = data[SPEED_W-1:0];
      CFG_START_X:       start_x = data[POS_W-1:0];
      CFG_START_Y:       start_y = data[POS_W-1:0];
      CFG_START_HEADING: start_heading = data[HEAD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void rotate_dist(input longint travel, input longint h_in,
                                      output longint dx, output longint dy);
    longint vx;
    longint vy;
    longint z;
    longint sx;
    longint sy;
    longint h;
    vx = (travel * INV_K) >>> 23;
    vy = 0;
    h = h_in;
    // fold the far half-plane onto the near one
    if (h > QUARTER) begin
      vx = -vx;
      h = h - HALF;
    end else if (h < -QUARTER) begin
      vx = -vx;
      h = h + HALF;
    end
    z = h * 65536;
    for (int i = 0; i < ROUNDS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (z >= 0) begin
        vx = vx - sy;
        vy = vy + sx;
        z = z - ATAN_TURN[i];
      end else begin
        vx = vx + sy;
        vy = vy - sx;
        z = z + ATAN_TURN[i];
      end
    end
    dx = (vx + 128) >>> 8;
    dy = (vy + 128) >>> 8;
  endfunction

  function automatic longint clamp_pos(input longint v, inout logic hit);
    if (v > POS_MAX) begin
      hit = 1'b1;
      return POS_MAX;
    end
    if (v < POS_MIN) begin
      hit = 1'b1;
      return POS_MIN;
    end
    return v;
  endfunction

  function automatic pose_t next_pose(input logic k, input logic [TS_W-1:0] ts);
    pose_t  p;
    longint travel;
    longint turn;
    longint dx;
    longint dy;
    logic   hit;
    hit = 1'b0;
    if (k == KIND_LOAD) begin
      cur_x = start_x;
      cur_y = start_y;
      cur_heading = start_heading;
    end else begin
      travel = (longint'(lin_speed) * longint'(ts) + 32768) >>> 16;
      turn = (longint'(ang_speed) * longint'(ts) + 32768) >>> 16;
      rotate_dist(travel, cur_heading, dx, dy);
      cur_x = clamp_pos(cur_x + dx, hit);
      cur_y = clamp_pos(cur_y + dy, hit);
      cur_heading = HEAD_W'(longint'(cur_heading) + turn);
    end
    p.x = cur_x[POS_W-1:0];
    p.y = cur_y[POS_W-1:0];
    p.heading = cur_heading;
    p.saturated = hit;
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t want;
    int    bad;
    bad = 0;
    if (rst) begin
      lin_speed = '0;
      ang_speed = '0;
      start_x = '0;
      start_y = '0;
      start_heading = '0;
      cur_x = 0;
      cur_y = 0;
      cur_heading = '0;
      pending_poses.delete();
      errors <= 0;
      poses_seen <= 0;
      sat_seen <= 0;
    end else begin
      if (cfg.valid && cfg.ready) mirror_write(cfg.index, cfg.data);
      if (pose.valid && pose.ready) begin
        poses_seen <= poses_seen + 1;
        if (pose.saturated === 1'b1) sat_seen <= sat_seen + 1;
        if (pending_poses.size() == 0) begin
          $error("pose beat with no item waiting: x %0d y %0d heading %0d",
                 pose.pose_x, pose.pose_y, pose.pose_heading);
          bad = 1;
        end else begin
          want = pending_poses.pop_front();
          if (pose.pose_x !== want.x) begin
            $error("pose_x: expected %0d, got %0d", want.x, pose.pose_x);
            bad++;
          end
          if (pose.pose_y !== want.y) begin
            $error("pose_y: expected %0d, got %0d", want.y, pose.pose_y);
            bad++;
          end
          if (pose.pose_heading !== want.heading) begin
            $error("pose_heading: expected %0d, got %0d", want.heading, pose.pose_heading);
            bad++;
          end
          if (pose.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, pose.saturated);
            bad++;
          end
        end
        errors <= errors + bad;
      end
      if (tick.valid && tick.ready) pending_poses.push_back(next_pose(tick.kind, tick.time_step));
    end
  end

endmodule

[test/unicycle_pose_integrator_top_tb.sv]
// testbench top: drives tick beats, register writes and pose backpressure, gives the verdict
module unicycle_pose_integrator_top_tb;
  import upi_pkg::*;

  localparam int STEPS       = 16;
  localparam int ITEM_TARGET = 1500;
  localparam int CALM_ITEMS  = 200;
  localparam int TAIL_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic       clk;
  logic       rst;
  logic       calm = 1'b0;
  logic       gappy = 1'b0;
  logic       sink_ready = 1'b1;
  int         ready_cnt;
  int         items_sent;
  int         loads_sent;
  int         writes_done;
  int         errors;
  int         poses_seen;
  int         sat_seen;
  reg_write_t reg_writes[$];

  upi_tick_if tick();
  upi_pose_if pose();
  upi_cfg_if  cfg();

  assign pose.ready = sink_ready;

  unicycle_pose_integrator_top #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .pose (pose),
    .cfg  (cfg)
  );

  upi_pose_checker #(.STEPS(STEPS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .pose       (pose),
    .cfg        (cfg),
    .errors     (errors),
    .poses_seen (poses_seen),
    .sat_seen   (sat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pose backpressure: random stall bursts between ready runs
  always @(posedge clk) begin
    if (rst || calm) begin
      sink_ready <= 1'b1;
      ready_cnt <= 0;
    end else if (ready_cnt != 0) begin
      ready_cnt <= ready_cnt - 1;
    end else if (sink_ready && $urandom_range(0, 2) == 0) begin
      sink_ready <= 1'b0;
      ready_cnt <= $urandom_range(0, 15);
    end else begin
      sink_ready <= 1'b1;
      ready_cnt <= $urandom_range(0, 40);
    end
  end

  function automatic void queue_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_writes.push_back(w);
  endfunction

  function automatic void queue_pose_regs(input logic [31:0] lin, input logic [31:0] ang,
                                          input logic [31:0] sx, input logic [31:0] sy,
                                          input logic [31:0] sh);
    queue_reg(CFG_LINEAR_SPEED, lin);
    queue_reg(CFG_ANGULAR_SPEED, ang);
    queue_reg(CFG_START_X, sx);
    queue_reg(CFG_START_Y, sy);
    queue_reg(CFG_START_HEADING, sh);
  endfunction

  function automatic logic [31:0] pick_word(input int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    case ($urandom_range(0, 7))
      0:       return 32'(hi);
      1:       return 32'(-hi - 1);
      2:       return 32'd0;
      3:       return 32'($urandom_range(1, 4095));
      4:       return -32'($urandom_range(1, 4095));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TS_W-1:0] pick_step();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2, 3:    return TS_W'($urandom_range(1, 255));
      default: return TS_W'($urandom());
    endcase
  endfunction

  // registers change only once every pose has come back
  task automatic apply_regs();
    wait (poses_seen == items_sent);
    foreach (reg_writes[i]) begin
      cfg.valid <= 1'b1;
      cfg.index <= reg_writes[i].idx;
      cfg.data <= reg_writes[i].data;
      do @(posedge clk); while (!cfg.ready);
      writes_done++;
    end
    cfg.valid <= 1'b0;
    reg_writes.delete();
  endtask

  task automatic send_tick(input logic k, input logic [TS_W-1:0] ts);
    if (gappy && !calm && $urandom_range(0, 2) == 0) begin
      tick.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    tick.valid <= 1'b1;
    tick.kind <= k;
    tick.time_step <= ts;
    do @(posedge clk); while (!tick.ready);
    items_sent++;
    if (k == KIND_LOAD) loads_sent++;
  endtask

  initial begin
    logic [15:0] sweep [7];
    int          n;
    sweep = '{16'h4000, 16'h4001, 16'hC000, 16'hBFFF, 16'h8000, 16'h7FFF, 16'h0001};
    rst <= 1'b1;
    tick.valid <= 1'b0;
    tick.kind <= KIND_ADVANCE;
    tick.time_step <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // registers at reset values
    send_tick(KIND_ADVANCE, 16'h0000);
    send_tick(KIND_ADVANCE, 16'hFFFF);
    send_tick(KIND_LOAD, 16'hFFFF);
    tick.valid <= 1'b0;

    // top speed near the upper corner: both positions clamp high
    queue_pose_regs(32'h007F_FFFF, 32'h007F_FFFF, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'd8192);
    apply_regs();
    send_tick(KIND_LOAD, 16'h0000);
    send_tick(KIND_ADVANCE, 16'hFFFF);
    tick.valid <= 1'b0;

    // heading past the quarter turn near the lower corner: both clamp low
    queue_pose_regs(32'h007F_FFFF, 32'h0080_0000, 32'h8000_0010, 32'h8000_0010,
                    32'hFFFF_A000);
    apply_regs();
    send_tick(KIND_LOAD, 16'h0000);
    send_tick(KIND_ADVANCE, 16'hFFFF);
    tick.valid <= 1'b0;

    // headings around the quarter turns and the half turn
    foreach (sweep[i]) begin
      queue_pose_regs(32'h000A_0000, 32'h0, 32'h0, 32'h0, {{16{sweep[i][15]}}, sweep[i]});
      apply_regs();
      send_tick(KIND_LOAD, 16'h0000);
      send_tick(KIND_ADVANCE, 16'h8000);
      tick.valid <= 1'b0;
    end

    // heading steps from just below pi onto minus pi, spare indexes written too
    queue_pose_regs(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0000_7FFF);
    queue_reg(CFG_SPARE_FIRST, 32'hFFFF_FFFF);
    queue_reg(CFG_SPARE_LAST, 32'h1234_5678);
    apply_regs();
    send_tick(KIND_LOAD, 16'h0000);
    send_tick(KIND_ADVANCE, 16'h0001);
    tick.valid <= 1'b0;

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
      gappy = !calm && $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 1)) queue_reg(CFG_LINEAR_SPEED, pick_word(SPEED_W));
      if ($urandom_range(0, 1)) queue_reg(CFG_ANGULAR_SPEED, pick_word(SPEED_W));
      if ($urandom_range(0, 1)) queue_reg(CFG_START_X, pick_word(POS_W));
      if ($urandom_range(0, 1)) queue_reg(CFG_START_Y, pick_word(POS_W));
      if ($urandom_range(0, 1)) queue_reg(CFG_START_HEADING, pick_word(HEAD_W));
      if ($urandom_range(0, 7) == 0)
        queue_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom());
      apply_regs();
      if ($urandom_range(0, 1)) send_tick(KIND_LOAD, TS_W'($urandom()));
      n = $urandom_range(10, 60);
      repeat (n) begin
        send_tick(($urandom_range(0, 9) == 0) ? KIND_LOAD : KIND_ADVANCE, pick_step());
      end
      tick.valid <= 1'b0;
    end

    wait (poses_seen == items_sent);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d poses (%0d loads, %0d clamped) over %0d register writes",
             poses_seen, loads_sent, sat_seen, writes_done);
    $display("cordic at %0d steps, random idling on both channels, last %0d items without",
             STEPS, CALM_ITEMS);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d items sent, %0d poses back", items_sent, poses_seen);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
